FILE: rtl/core/spike_trace_record_replay_top_defines.svh
// ----------------------------------------------------------------------------
// Spike trace record/replay assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPIKE_TRACE_RECORD_REPLAY_TOP_DEFINES_SVH
`define SPIKE_TRACE_RECORD_REPLAY_TOP_DEFINES_SVH

// property holds at every edge out of reset
`define STRR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define STRR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STRR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/strr_pkg.sv
// ----------------------------------------------------------------------------
// Spike trace record/replay package
// Sizes, opcodes, register indexes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package strr_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int MAX_EMIT    = 64;
	localparam int EMIT_W      = $clog2(MAX_EMIT + 1);

	localparam int TIME_W      = 64;
	localparam int ID_W        = 64;
	localparam int OP_W        = 4;

	localparam int SPEED_W     = 12;
	localparam logic [SPEED_W-1:0] SPEED_MIN   = 12'd26;
	localparam logic [SPEED_W-1:0] SPEED_MAX   = 12'd2560;
	localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;

	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = SPEED_W;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP  = 4'd1;

	typedef enum logic [OP_W-1:0] {
		OP_REC_START = 4'd0,
		OP_REC_STOP  = 4'd1,
		OP_SPIKE     = 4'd2,
		OP_PLAY      = 4'd3,
		OP_PAUSE     = 4'd4,
		OP_STOP      = 4'd5,
		OP_SEEK      = 4'd6,
		OP_TICK      = 4'd7,
		OP_CLEAR     = 4'd8
	} op_t;

	typedef struct packed {
		logic [TIME_W-1:0] stime;
		logic [ID_W-1:0]   source;
		logic [ID_W-1:0]   target;
		logic [ID_W-1:0]   synapse;
	} spike_t;

	// controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic rec_start;
		logic rec_store;
		logic rewind;
		logic clear_all;
		logic seek_clamp;
		logic seek_rd;
		logic seek_hit;
		logic seek_next;
		logic mul;
		logic add;
		logic adv;
		logic em_rd;
		logic take;
		logic push;
		logic push_last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic count_zero;
		logic full;
		logic scan_lt;
		logic hit;
		logic due;
		logic em_more;
		logic have_pend;
		logic out_free;
		logic at_end;
		logic loop_en;
	} sts_t;

endpackage

FILE: rtl/core/strr_item_if.sv
// ----------------------------------------------------------------------------
// Command item channel
// valid/ready channel carrying one command and its arguments per beat.
// ----------------------------------------------------------------------------
interface strr_item_if;
	import strr_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [TIME_W-1:0] spike_time;
	logic [ID_W-1:0]   source_id;
	logic [ID_W-1:0]   target_id;
	logic [ID_W-1:0]   synapse_id;
	logic [TIME_W-1:0] time_arg;

	modport source (
		output valid, opcode, spike_time, source_id, target_id, synapse_id, time_arg,
		input  ready
	);
	modport sink (
		input  valid, opcode, spike_time, source_id, target_id, synapse_id, time_arg,
		output ready
	);
endinterface

FILE: rtl/core/strr_result_if.sv
// ----------------------------------------------------------------------------
// Replayed spike channel
// valid/ready channel carrying one replayed spike per beat.
// ----------------------------------------------------------------------------
interface strr_result_if;
	import strr_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] out_time;
	logic [ID_W-1:0]   out_source;
	logic [ID_W-1:0]   out_target;
	logic [ID_W-1:0]   out_synapse;
	logic              last_of_run;

	modport source (
		output valid, out_time, out_source, out_target, out_synapse, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, out_time, out_source, out_target, out_synapse, last_of_run,
		output ready
	);
endinterface

FILE: rtl/core/strr_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// valid/ready register write: index and data per beat.
// ----------------------------------------------------------------------------
interface strr_cfg_if;
	import strr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/spike_trace_record_replay_top.sv
// ----------------------------------------------------------------------------
// Spike trace record/replay top level
// Spike event recorder with timed, speed-scaled replay from a 1024-entry store.
// ----------------------------------------------------------------------------
// Channels: item carries one command (opcode plus spike fields and time_arg)
// per beat; result carries one replayed spike per beat, last_of_run marking
// the final spike of a tick; cfg writes speed_q8 (index 0, clamped to
// 26..2560) and loop_enable (index 1), taken every cycle.
// Sequencing: one command is in flight at a time. Record, play, pause,
// stop, clear and a tick that does not run pass accept, then execute. Seek
// clamps the target, then reads and compares stored entries one at a time
// through the single read port of the store, until the first one at or
// after the target or until none is left. A running tick scales the step
// (multiply, add, advance), then reads each stored spike and checks that
// it is due, stopping at a spike not yet due or after at most 64 spikes.
// Reset clears the mode flags, counters and replay times and loads speed
// 256 and loop off. The store itself is not cleared; only written entries
// below the fill count are ever read, so no clearing pass runs.
// A stalled receiver holds the output register; the replay walk waits on it
// and resumes without loss. The next command is taken once the walk ends,
// even while its last result is still held.
// ----------------------------------------------------------------------------
module spike_trace_record_replay_top (
	input  logic          clk,
	input  logic          arst_n,
	strr_item_if.sink     item,
	strr_result_if.source result,
	strr_cfg_if.sink      cfg
);
	import strr_pkg::*;

	cmd_t cmd;   // sequencing commands
	sts_t sts;   // datapath compare and flag results

	// command decode, mode flags, seek and tick sequencing
	strr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// store, time arithmetic, handshake and output register
	strr_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

FILE: rtl/core/strr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module strr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/core/strr_datapath.sv
// ----------------------------------------------------------------------------
// Spike trace datapath
// Item capture, trace store, replay time arithmetic, output register.
// ----------------------------------------------------------------------------
`include "spike_trace_record_replay_top_defines.svh"

module strr_datapath (
	input  logic           clk,
	input  logic           arst_n,
	strr_item_if.sink      item,
	strr_result_if.source  result,
	strr_cfg_if.sink       cfg,
	input  strr_pkg::cmd_t cmd,
	output strr_pkg::sts_t sts
);
	import strr_pkg::*;

	// captured item
	logic [OP_W-1:0]   op_q;
	spike_t            spk_q;
	logic [TIME_W-1:0] arg_q;

	// config
	logic [SPEED_W-1:0] speed_q;
	logic               loop_q;
	logic [SPEED_W-1:0] speed_clamped;

	// replay state
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  scan_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] first_q;
	logic [TIME_W-1:0] final_q;
	logic [EMIT_W-1:0] n_q;
	logic              have_pend_q;
	spike_t            pend_q;

	// scaled delta
	logic [43:0]       p0_q;
	logic [67:0]       p1_q;
	logic [11:0]       plo_q;
	logic [TIME_W-1:0] delta_q;
	logic [67:0]       sum_full;
	logic [19:0]       lo_prod;
	logic [TIME_W:0]   now_sum;
	logic [TIME_W-1:0] seek_t0;
	logic [TIME_W-1:0] seek_t;

	// store
	spike_t            rd_spk;
	logic [ADDR_W-1:0] raddr;
	logic              accept;

	// output register
	logic              out_valid_q;
	spike_t            out_q;
	logic              out_last_q;

	assign accept    = item.valid & item.ready;
	assign item.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q          <= item.opcode;
			spk_q.stime   <= item.spike_time;
			spk_q.source  <= item.source_id;
			spk_q.target  <= item.target_id;
			spk_q.synapse <= item.synapse_id;
			arg_q         <= item.time_arg;
		end
	end

	always_comb begin
		speed_clamped = cfg.data[SPEED_W-1:0];
		if (speed_clamped < SPEED_MIN) begin
			speed_clamped = SPEED_MIN;
		end else if (speed_clamped > SPEED_MAX) begin
			speed_clamped = SPEED_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			loop_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SPEED: speed_q <= speed_clamped;
				REG_LOOP:  loop_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	strr_ram #(
		.WIDTH ($bits(spike_t)),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.rec_store),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (spk_q),
		.re    (cmd.seek_rd | cmd.em_rd),
		.raddr (raddr),
		.rdata (rd_spk)
	);

	assign raddr = cmd.seek_rd ? scan_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	// floor(arg * speed / 256): arg[63:8]*speed split in two partial products
	assign lo_prod  = 20'(arg_q[7:0]) * 20'(speed_q);
	assign sum_full = p1_q + 68'(p0_q) + 68'(plo_q);
	assign now_sum  = {1'b0, now_q} + {1'b0, delta_q};

	always_comb begin
		seek_t0 = (arg_q > final_q) ? final_q : arg_q;
		seek_t  = (seek_t0 < first_q) ? first_q : seek_t0;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p0_q  <= 44'(arg_q[39:8]) * 44'(speed_q);
			p1_q  <= {36'(arg_q[63:40]) * 36'(speed_q), 32'd0};
			plo_q <= lo_prod[19:8];
		end
		if (cmd.add) begin
			delta_q <= (|sum_full[67:64]) ? '1 : sum_full[63:0];
		end
		if (cmd.take) begin
			pend_q <= rd_spk;
		end
		if (cmd.push) begin
			out_q      <= pend_q;
			out_last_q <= cmd.push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			scan_q      <= '0;
			now_q       <= '0;
			first_q     <= '0;
			final_q     <= '0;
			n_q         <= '0;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (cmd.clear_all) begin
				count_q <= '0;
				idx_q   <= '0;
				now_q   <= '0;
				first_q <= '0;
				final_q <= '0;
			end else if (cmd.rec_start) begin
				count_q <= '0;
				first_q <= '0;
				final_q <= '0;
			end else if (cmd.rec_store) begin
				if (count_q == '0) begin
					first_q <= spk_q.stime;
				end
				final_q <= spk_q.stime;
				count_q <= count_q + 1'b1;
			end else if (cmd.rewind) begin
				now_q <= first_q;
				idx_q <= '0;
			end else if (cmd.seek_clamp) begin
				now_q  <= seek_t;
				idx_q  <= '0;
				scan_q <= '0;
			end else if (cmd.seek_hit) begin
				idx_q <= scan_q;
			end else if (cmd.seek_next) begin
				scan_q <= scan_q + 1'b1;
			end else if (cmd.adv) begin
				now_q       <= now_sum[TIME_W] ? '1 : now_sum[TIME_W-1:0];
				n_q         <= '0;
				have_pend_q <= 1'b0;
			end else if (cmd.take) begin
				idx_q       <= idx_q + 1'b1;
				n_q         <= n_q + 1'b1;
				have_pend_q <= 1'b1;
			end else begin
				// no replay state update this cycle
			end

			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_time    = out_q.stime;
	assign result.out_source  = out_q.source;
	assign result.out_target  = out_q.target;
	assign result.out_synapse = out_q.synapse;
	assign result.last_of_run = out_last_q;

	always_comb begin
		sts.in_valid   = item.valid;
		sts.op         = op_t'(op_q);
		sts.count_zero = (count_q == '0);
		sts.full       = (count_q == CNT_W'(STORE_DEPTH));
		sts.scan_lt    = (scan_q < count_q);
		sts.hit        = (rd_spk.stime >= now_q);
		sts.due        = (rd_spk.stime <= now_q);
		sts.em_more    = (idx_q < count_q) && (n_q < EMIT_W'(MAX_EMIT));
		sts.have_pend  = have_pend_q;
		sts.out_free   = !out_valid_q || result.ready;
		sts.at_end     = (now_q >= final_q);
		sts.loop_en    = loop_q;
	end

	`STRR_ASSERT(a_count_bound, count_q <= CNT_W'(STORE_DEPTH), "store count past depth")
	`STRR_ASSERT(a_emit_bound, n_q <= EMIT_W'(MAX_EMIT), "emit count past cap")
	`STRR_ASSERT_IMP(a_push_free, cmd.push, !out_valid_q || result.ready, "push over held beat")
endmodule

FILE: rtl/core/strr_ctrl.sv
// ----------------------------------------------------------------------------
// Spike trace controller
// Command decode, mode flags and sequencing of seek scan and tick replay.
// ----------------------------------------------------------------------------
`include "spike_trace_record_replay_top_defines.svh"

module strr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  strr_pkg::sts_t sts,
	output strr_pkg::cmd_t cmd
);
	import strr_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_EXEC     = 11'b000_0000_0010,
		S_SEEK_RD  = 11'b000_0000_0100,
		S_SEEK_CMP = 11'b000_0000_1000,
		S_MUL      = 11'b000_0001_0000,
		S_ADD      = 11'b000_0010_0000,
		S_ADV      = 11'b000_0100_0000,
		S_EM_RD    = 11'b000_1000_0000,
		S_EM_CHK   = 11'b001_0000_0000,
		S_FLUSH    = 11'b010_0000_0000,
		S_END      = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   rec_q, rec_d;
	logic   play_q, play_d;
	logic   pause_q, pause_d;

	always_comb begin
		state_d = state_q;
		rec_d   = rec_q;
		play_d  = play_q;
		pause_d = pause_q;
		cmd     = '0;

		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (sts.op)
					OP_REC_START: begin
						if (!rec_q) begin
							rec_d         = 1'b1;
							cmd.rec_start = 1'b1;
						end
					end
					OP_REC_STOP: begin
						if (rec_q) begin
							rec_d      = 1'b0;
							cmd.rewind = 1'b1;
						end
					end
					OP_SPIKE: begin
						cmd.rec_store = rec_q && !sts.full;
					end
					OP_PLAY: begin
						if (!sts.count_zero) begin
							play_d  = 1'b1;
							pause_d = 1'b0;
						end
					end
					OP_PAUSE: pause_d = 1'b1;
					OP_STOP: begin
						play_d     = 1'b0;
						pause_d    = 1'b0;
						cmd.rewind = 1'b1;
					end
					OP_SEEK: begin
						cmd.seek_clamp = 1'b1;
						state_d        = S_SEEK_RD;
					end
					OP_TICK: begin
						if (play_q && !pause_q && !sts.count_zero) begin
							state_d = S_MUL;
						end
					end
					OP_CLEAR: begin
						cmd.clear_all = 1'b1;
						play_d        = 1'b0;
						pause_d       = 1'b0;
					end
					default: ;
				endcase
			end
			S_SEEK_RD: begin
				if (sts.scan_lt) begin
					cmd.seek_rd = 1'b1;
					state_d     = S_SEEK_CMP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SEEK_CMP: begin
				if (sts.hit) begin
					cmd.seek_hit = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.seek_next = 1'b1;
					state_d       = S_SEEK_RD;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_ADV;
			end
			S_ADV: begin
				cmd.adv = 1'b1;
				state_d = S_EM_RD;
			end
			S_EM_RD: begin
				if (sts.em_more) begin
					cmd.em_rd = 1'b1;
					state_d   = S_EM_CHK;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_EM_CHK: begin
				// a due spike releases the one held before it as not last
				if (sts.due) begin
					if (!sts.have_pend || sts.out_free) begin
						cmd.push = sts.have_pend;
						cmd.take = 1'b1;
						state_d  = S_EM_RD;
					end
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!sts.have_pend) begin
					state_d = S_END;
				end else if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = S_END;
				end
			end
			S_END: begin
				state_d = S_IDLE;
				if (sts.at_end) begin
					cmd.rewind = 1'b1;
					if (!sts.loop_en) begin
						play_d  = 1'b0;
						pause_d = 1'b0;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rec_q   <= 1'b0;
			play_q  <= 1'b0;
			pause_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rec_q   <= rec_d;
			play_q  <= play_d;
			pause_q <= pause_d;
		end
	end

	`STRR_ASSERT_IMP(a_tick_gated, state_q == S_MUL, play_q && !pause_q, "tick run while halted")
	`STRR_ASSERT_IMP(a_take_room, cmd.take, sts.em_more, "spike taken past cap or count")
	`STRR_ASSERT_NXT(a_last_ends, cmd.push && cmd.push_last, state_q == S_END, "last beat not at end")
endmodule

FILE: bench/spike_trace_record_replay_checker.sv
// ----------------------------------------------------------------------------
// Spike trace replay checker
// Watches the command, replay and register channels, keeps its own copy of
// the trace store and replay state, and compares every replayed spike.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spike_trace_record_replay_checker (
	input  logic   clk,
	input  logic   arst_n,
	strr_item_if   item,
	strr_result_if result,
	strr_cfg_if    cfg,
	output int     fail_count,
	output int     open_count
);
	import strr_pkg::*;

	localparam int Q8_FRAC   = 8;
	localparam int PROD_W    = TIME_W + SPEED_W;

	typedef struct packed {
		spike_t spk;
		logic   last;
	} replay_beat_t;

	// trace store and replay state
	logic [TIME_W-1:0] trace_stamp [STORE_DEPTH];
	logic [ID_W-1:0]   trace_src   [STORE_DEPTH];
	logic [ID_W-1:0]   trace_dst   [STORE_DEPTH];
	logic [ID_W-1:0]   trace_syn   [STORE_DEPTH];
	int                fill_cnt;
	int                walk_pos;
	logic [TIME_W-1:0] play_now;
	logic [TIME_W-1:0] win_start;
	logic [TIME_W-1:0] win_end;
	logic              recording;
	logic              playing;
	logic              paused;
	logic [SPEED_W-1:0] speed_q;
	logic              looping;

	replay_beat_t replay_due[$];

	task automatic report(string what);
		$display("[%0t] replay check: %s", $time, what);
		fail_count++;
	endtask

	// floor(span * q8 / 256), saturated
	function automatic logic [TIME_W-1:0] scaled_step(logic [TIME_W-1:0] span,
			logic [SPEED_W-1:0] q8);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(span) * PROD_W'(q8);
		prod = prod >> Q8_FRAC;
		if (prod[PROD_W-1:TIME_W] != '0)
			return '1;
		return prod[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	task automatic halt_replay();
		playing  = 1'b0;
		paused   = 1'b0;
		play_now = win_start;
		walk_pos = 0;
	endtask

	task automatic apply_command(logic [OP_W-1:0] opc, logic [TIME_W-1:0] stamp,
			logic [ID_W-1:0] src, logic [ID_W-1:0] dst, logic [ID_W-1:0] syn,
			logic [TIME_W-1:0] targ);
		int           emitted;
		logic         found;
		replay_beat_t b;
		emitted = 0;
		found   = 1'b0;
		case (opc)
			OP_REC_START: if (!recording) begin
				recording = 1'b1;
				fill_cnt  = 0;
				win_start = '0;
				win_end   = '0;
			end
			OP_REC_STOP: if (recording) begin
				recording = 1'b0;
				play_now  = win_start;
				walk_pos  = 0;
			end
			OP_SPIKE: if (recording && fill_cnt < STORE_DEPTH) begin
				if (fill_cnt == 0)
					win_start = stamp;
				trace_stamp[ADDR_W'(fill_cnt)] = stamp;
				trace_src[ADDR_W'(fill_cnt)]   = src;
				trace_dst[ADDR_W'(fill_cnt)]   = dst;
				trace_syn[ADDR_W'(fill_cnt)]   = syn;
				win_end = stamp;
				fill_cnt++;
			end
			OP_PLAY: if (fill_cnt != 0) begin
				playing = 1'b1;
				paused  = 1'b0;
			end
			OP_PAUSE: paused = 1'b1;
			OP_STOP: halt_replay();
			OP_SEEK: begin
				play_now = (targ > win_end) ? win_end : targ;
				if (play_now < win_start)
					play_now = win_start;
				walk_pos = 0;
				for (int i = 0; i < fill_cnt; i++) begin
					if (!found && trace_stamp[ADDR_W'(i)] >= play_now) begin
						walk_pos = i;
						found    = 1'b1;
					end
				end
			end
			OP_TICK: if (playing && !paused && fill_cnt != 0) begin
				play_now = sat_sum(play_now, scaled_step(targ, speed_q));
				while (emitted < MAX_EMIT && walk_pos < fill_cnt &&
						trace_stamp[ADDR_W'(walk_pos)] <= play_now) begin
					b.spk.stime   = trace_stamp[ADDR_W'(walk_pos)];
					b.spk.source  = trace_src[ADDR_W'(walk_pos)];
					b.spk.target  = trace_dst[ADDR_W'(walk_pos)];
					b.spk.synapse = trace_syn[ADDR_W'(walk_pos)];
					b.last        = 1'b0;
					replay_due    = {replay_due, b};
					walk_pos++;
					emitted++;
				end
				// b still holds the final beat of this tick
				if (emitted > 0) begin
					b.last = 1'b1;
					replay_due[replay_due.size() - 1] = b;
				end
				// end of window: wrap or stop
				if (play_now >= win_end) begin
					if (looping) begin
						play_now = win_start;
						walk_pos = 0;
					end else begin
						halt_replay();
					end
				end
			end
			OP_CLEAR: begin
				fill_cnt  = 0;
				walk_pos  = 0;
				play_now  = '0;
				win_start = '0;
				win_end   = '0;
				playing   = 1'b0;
				paused    = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_beat();
		replay_beat_t e;
		if (replay_due.size() == 0) begin
			report($sformatf("unexpected spike, time %0h", result.out_time));
			return;
		end
		e = replay_due.pop_front();
		check_field("out_time", result.out_time, e.spk.stime);
		check_field("out_source", result.out_source, e.spk.source);
		check_field("out_target", result.out_target, e.spk.target);
		check_field("out_synapse", result.out_synapse, e.spk.synapse);
		check_field("last_of_run", TIME_W'(result.last_of_run), TIME_W'(e.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt   = 0;
			walk_pos   = 0;
			play_now   = '0;
			win_start  = '0;
			win_end    = '0;
			recording  = 1'b0;
			playing    = 1'b0;
			paused     = 1'b0;
			speed_q    = SPEED_RESET;
			looping    = 1'b0;
			fail_count = 0;
			replay_due.delete();
			open_count <= 0;
		end else begin
			// spikes of a previous tick go out before a new command can emit
			if (result.valid && result.ready)
				check_beat();
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SPEED) begin
					speed_q = cfg.data;
					if (speed_q < SPEED_MIN)
						speed_q = SPEED_MIN;
					if (speed_q > SPEED_MAX)
						speed_q = SPEED_MAX;
				end else if (cfg.index == REG_LOOP) begin
					looping = cfg.data[0];
				end
			end
			if (item.valid && item.ready)
				apply_command(item.opcode, item.spike_time, item.source_id,
					item.target_id, item.synapse_id, item.time_arg);
			open_count <= replay_due.size();
		end
	end

endmodule

FILE: bench/spike_trace_record_replay_top_test.sv
// ----------------------------------------------------------------------------
// Spike trace record/replay testbench
// Records spike traces and replays them under varying speed and loop
// settings, with random sender bursts and receiver stalls; a checker module
// predicts and compares every replayed spike.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spike_trace_record_replay_top_test;
	import strr_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RANDOM_CMDS = 225;
	localparam int CAP_SPIKES  = MAX_EMIT + 20;       // enough to pass the per-tick cap
	// worst command: seek scanning the whole store
	localparam int SETTLE      = 3 + 2 * STORE_DEPTH + 32;
	localparam int QUIET_LIMIT = 20000;
	localparam int Q8_ONE      = 256;
	localparam int SPEED_PICKS = 7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_LOOP + 1'b1;
	localparam logic [OP_W-1:0]      OP_SPARE  = '1;

	logic clk = 1'b0;
	logic arst_n;

	strr_item_if   item ();
	strr_result_if result ();
	strr_cfg_if    cfg ();

	int fail_count;
	int open_count;

	int cmds_sent;
	int reg_writes;
	int spikes_seen;
	int quiet;
	int burst_left;
	int stall_left;
	int stall_mode;
	logic [SPEED_W-1:0] speed_hint = SPEED_RESET;   // rough speed, only to size ticks

	always #(HALF_PERIOD) clk = ~clk;

	spike_trace_record_replay_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	spike_trace_record_replay_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg        (cfg),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	// Receiver: switches at random intervals between always ready, coin flip,
	// rare stalls and long stalls (ready only a quarter of the time).
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: result.ready <= 1'b1;
			1: result.ready <= 1'($urandom_range(0, 1));
			2: result.ready <= ($urandom_range(0, 7) != 0);
			default: result.ready <= (stall_left % 32) < 8;
		endcase
	end

	// Watchdog on beats of any channel; also counts replayed spikes.
	always @(posedge clk) begin
		if (result.valid && result.ready)
			spikes_seen <= spikes_seen + 1;
		if ((item.valid && item.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("[%0t] no beat for %0d cycles", $time, quiet);
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// One command beat. The sender runs in bursts and drops valid between
	// bursts. Long bursts give stretches with no idling.
	task automatic send_cmd(logic [OP_W-1:0] opc, logic [TIME_W-1:0] stamp,
			logic [ID_W-1:0] src, logic [ID_W-1:0] dst, logic [ID_W-1:0] syn,
			logic [TIME_W-1:0] targ);
		if (burst_left == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		item.valid      <= 1'b1;
		item.opcode     <= opc;
		item.spike_time <= stamp;
		item.source_id  <= src;
		item.target_id  <= dst;
		item.synapse_id <= syn;
		item.time_arg   <= targ;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		burst_left--;
		cmds_sent++;
	endtask

	// command whose spike fields are don't-care: fill them with noise
	task automatic any_cmd(logic [OP_W-1:0] opc, logic [TIME_W-1:0] targ);
		send_cmd(opc, rand64(), rand64(), rand64(), rand64(), targ);
	endtask

	// Quiesce: drop valid, drain expected spikes, then cover a command that
	// emits nothing (a full-store seek is the slowest).
	task automatic wait_idle();
		item.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		reg_writes++;
	endtask

	task automatic write_regs(logic [CFG_DATA_W-1:0] sp, logic [CFG_DATA_W-1:0] lp,
			logic with_spare);
		if (with_spare)
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		if ($urandom_range(0, 1)) begin
			write_reg(REG_SPEED, sp);
			write_reg(REG_LOOP, lp);
		end else begin
			write_reg(REG_LOOP, lp);
			write_reg(REG_SPEED, sp);
		end
		cfg.valid <= 1'b0;
		speed_hint = (sp < SPEED_MIN) ? SPEED_MIN : (sp > SPEED_MAX) ? SPEED_MAX : sp;
	endtask

	// Tick length: mostly a fraction of the recorded span at the current
	// speed, sometimes zero or a huge value that saturates the clock.
	function automatic logic [TIME_W-1:0] tick_arg(logic [TIME_W-1:0] span);
		logic [TIME_W-1:0] part;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return rand64();
			default: begin
				part = (span >> $urandom_range(0, 4)) + TIME_W'(1);
				return part * TIME_W'(Q8_ONE) / TIME_W'(speed_hint)
					+ TIME_W'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// Record a trace with mostly nondecreasing times, then replay it with a
	// mix of ticks, seeks and play control.
	task automatic replay_episode();
		int                n;
		int                pick;
		logic [TIME_W-1:0] stamp;
		logic [TIME_W-1:0] t_first;
		logic [TIME_W-1:0] t_last;
		logic [TIME_W-1:0] gap;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
		case ($urandom_range(0, 3))
			0: stamp = '0;
			1: stamp = TIME_W'($urandom_range(0, 5000));
			2: stamp = rand64();
			default: stamp = '1 - TIME_W'($urandom_range(0, 3000));   // near the top
		endcase
		t_first = stamp;
		t_last  = stamp;
		any_cmd(OP_REC_START, rand64());
		repeat (n) begin
			if ($urandom_range(0, 15) == 0) begin
				any_cmd(OP_SPIKE, rand64());      // out-of-order time
			end else begin
				send_cmd(OP_SPIKE, stamp, rand64(), rand64(), rand64(), rand64());
				t_last = stamp;
				gap = ($urandom_range(0, 3) == 0) ? '0 : TIME_W'($urandom_range(1, 1000));
				stamp = (stamp > '1 - gap) ? '1 : stamp + gap;
			end
		end
		if ($urandom_range(0, 9) != 0)
			any_cmd(OP_REC_STOP, rand64());
		any_cmd(OP_PLAY, rand64());
		repeat ($urandom_range(3, 14)) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				any_cmd(OP_TICK, tick_arg(t_last - t_first));
			else if (pick < 72)
				any_cmd(OP_SEEK, ($urandom_range(0, 3) == 0) ? rand64()
					: t_first + (t_last - t_first) * TIME_W'($urandom_range(0, 10)) / 8);
			else if (pick < 78)
				any_cmd(OP_PAUSE, rand64());
			else if (pick < 86)
				any_cmd(OP_PLAY, rand64());
			else if (pick < 91)
				any_cmd(OP_STOP, rand64());
			else if (pick < 94)
				any_cmd(OP_REC_START, rand64());
			else if (pick < 97)
				any_cmd(OP_W'($urandom_range(OP_CLEAR + 1, OP_SPARE)), rand64());
			else
				any_cmd(OP_TICK, rand64());
		end
		if ($urandom_range(0, 2) == 0)
			any_cmd(OP_CLEAR, rand64());
		else
			any_cmd(OP_STOP, rand64());
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] speed_picks [SPEED_PICKS];
		logic [CFG_DATA_W-1:0] lp;
		int base;
		int phase;
		int phase_left;

		speed_picks = '{'0, '1, SPEED_MIN, SPEED_MAX, SPEED_MIN - 1'b1,
			SPEED_MAX + 1'b1, SPEED_RESET};
		phase      = 0;
		phase_left = 0;

		arst_n          <= 1'b0;
		item.valid      <= 1'b0;
		item.opcode     <= OP_REC_START;
		item.spike_time <= '0;
		item.source_id  <= '0;
		item.target_id  <= '0;
		item.synapse_id <= '0;
		item.time_arg   <= '0;
		cfg.valid       <= 1'b0;
		cfg.index       <= REG_SPEED;
		cfg.data        <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings (speed 1.0, loop off).
		// Commands that must be ignored on an idle, empty block.
		any_cmd(OP_TICK, '0);
		any_cmd(OP_PLAY, rand64());
		send_cmd(OP_SPIKE, 64'd7, rand64(), rand64(), rand64(), rand64());
		any_cmd(OP_REC_STOP, rand64());
		// four-entry trace: field extremes and a repeated time
		any_cmd(OP_REC_START, rand64());
		send_cmd(OP_SPIKE, 64'd0, '0, '0, '0, '0);
		send_cmd(OP_SPIKE, 64'd5, '1, '1, '1, '1);
		send_cmd(OP_SPIKE, 64'd5, rand64(), rand64(), rand64(), rand64());
		send_cmd(OP_SPIKE, 64'd100, rand64(), rand64(), rand64(), rand64());
		any_cmd(OP_REC_START, rand64());            // ignored while recording
		any_cmd(OP_REC_STOP, rand64());
		any_cmd(OP_PLAY, rand64());
		any_cmd(OP_TICK, 64'd4);                    // first spike only
		any_cmd(OP_PAUSE, rand64());
		any_cmd(OP_TICK, 64'd1000);                 // paused: nothing
		any_cmd(OP_PLAY, rand64());
		any_cmd(OP_SEEK, 64'd3);                    // lands on second entry
		any_cmd(OP_TICK, 64'd2);                    // both time-5 spikes
		any_cmd(OP_SEEK, '1);                       // clamped to the end
		any_cmd(OP_SEEK, '0);                       // clamped to the start
		any_cmd(OP_TICK, '1);                       // saturating tick, then stop
		any_cmd(OP_STOP, rand64());
		any_cmd(OP_CLEAR, rand64());
		any_cmd(OP_TICK, rand64());                 // cleared: nothing
		any_cmd(OP_SPARE, rand64());                // unused opcode

		// Random part: record/replay episodes and noise, with a new register
		// setting every few episodes. Clamp extremes come first, one each.
		base = cmds_sent;
		while (cmds_sent - base < RANDOM_CMDS) begin
			if (phase_left == 0) begin
				wait_idle();
				lp = (phase == 0) ? CFG_DATA_W'(1) : (phase == 1) ? '0
					: CFG_DATA_W'($urandom);
				write_regs((phase < SPEED_PICKS) ? speed_picks[phase]
					: CFG_DATA_W'($urandom), lp, phase == 2);
				phase++;
				phase_left = (phase < SPEED_PICKS) ? 1 : int'($urandom_range(1, 3));
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(2, 8))
					send_cmd(OP_W'($urandom_range(0, OP_SPARE)), rand64(), rand64(),
						rand64(), rand64(), rand64());
			end else begin
				replay_episode();
			end
			phase_left--;
		end

		// Capped replay: times 0..CAP_SPIKES-1 at speed 1.0, loop on. A tick
		// with more due spikes than the cap leaves the rest for the next one.
		wait_idle();
		write_regs(SPEED_RESET, CFG_DATA_W'(1), 1'b0);
		any_cmd(OP_CLEAR, rand64());
		any_cmd(OP_REC_START, rand64());
		for (int i = 0; i < CAP_SPIKES; i++)
			send_cmd(OP_SPIKE, TIME_W'(i), rand64(), rand64(), rand64(), rand64());
		any_cmd(OP_REC_STOP, rand64());
		any_cmd(OP_PLAY, rand64());
		any_cmd(OP_TICK, 64'd70);                   // 71 due, capped
		any_cmd(OP_TICK, 64'd1);                    // the held-over spikes
		any_cmd(OP_SEEK, TIME_W'(CAP_SPIKES - 1));
		any_cmd(OP_SEEK, TIME_W'(CAP_SPIKES / 2));
		any_cmd(OP_TICK, '1);                       // the rest of the trace, then wraps
		any_cmd(OP_TICK, 64'd2000);
		any_cmd(OP_STOP, rand64());
		any_cmd(OP_CLEAR, rand64());

		wait_idle();
		$display("summary: %0d commands, %0d register writes, %0d replayed spikes compared",
			cmds_sent, reg_writes, spikes_seen);
		$display("summary: speed swept across its clamp limits, loop on and off, tick cap hit");
		if (fail_count == 0 && open_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
